/* src/tpd_pkg.sv */
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared constants and types for the touchpad packet deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

    // Packet geometry.
    localparam int PACKET_BYTES = 6;
    localparam int POS_W        = 3;
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC2 = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PACKET_BYTES - 1);

    // Sync patterns carried in the top two bits of bytes zero and three.
    localparam logic [1:0] SYNC_TOP_FIRST = 2'b10;
    localparam logic [1:0] SYNC_TOP_SECOND = 2'b11;

    // Bit position that must be clear in both sync bytes.
    localparam int SYNC_CLEAR_BIT = 3;

    // Non-extended width code reported for a finger present.
    localparam logic [3:0] WIDTH_FINGER = 4'd4;
    localparam logic [3:0] WIDTH_NONE   = 4'd0;

    // One complete six-byte packet.
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [7:0] byte3;
        logic [7:0] byte4;
        logic [7:0] byte5;
    } packet_t;

    // Decoded result of one packet.
    typedef struct packed {
        logic [1:0]  button_bits;
        logic [7:0]  pressure;
        logic [3:0]  finger_width;
        logic        gesture_flag;
        logic [12:0] x_position;
        logic [12:0] y_position;
    } result_t;

endpackage

/* src/tpd_framer.sv */
// ----------------------------------------------------------------------------
// tpd_framer
// Tracks the byte position, checks sync bits and stores packet bytes.
// ----------------------------------------------------------------------------
module tpd_framer
    import tpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       take,
    output logic       packet_done,
    output packet_t    packet
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       store_reg [PACKET_BYTES-1];
    logic             sync_bad;
    logic             first_bad;
    logic             second_bad;
    logic             checks_ok;
    logic             is_last;

    // Sync checks on the byte held in the input register.
    always_comb
    begin
        sync_bad   = ((pos_reg == POS_FIRST) || (pos_reg == POS_SYNC2))
                     && byte_data[SYNC_CLEAR_BIT];
        first_bad  = (pos_reg == POS_FIRST) && (byte_data[7:6] != SYNC_TOP_FIRST);
        second_bad = (pos_reg == POS_SYNC2) && (byte_data[7:6] != SYNC_TOP_SECOND);
        checks_ok  = !sync_bad && !first_bad && !second_bad;
        is_last    = (pos_reg >= POS_LAST);
    end

    assign packet_done = byte_valid && checks_ok && is_last;

    // Next byte position: any failed check or a completed packet restarts.
    always_comb
    begin
        if (!checks_ok || is_last)
        begin
            pos_next = POS_FIRST;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_FIRST;
        end
        else if (take)
        begin
            pos_reg <= pos_next;
        end
    end

    // Packet bytes before the last one are kept until the packet completes.
    always_ff @(posedge clk)
    begin
        if (take && checks_ok && !is_last)
        begin
            store_reg[pos_reg] <= byte_data;
        end
    end

    assign packet.byte0 = store_reg[0];
    assign packet.byte1 = store_reg[1];
    assign packet.byte2 = store_reg[2];
    assign packet.byte3 = store_reg[3];
    assign packet.byte4 = store_reg[4];
    assign packet.byte5 = byte_data;

endmodule

/* src/tpd_decode.sv */
// ----------------------------------------------------------------------------
// tpd_decode
// Unpacks a complete packet into buttons, pressure, width and position.
// ----------------------------------------------------------------------------
module tpd_decode
    import tpd_pkg::*;
(
    input  packet_t packet,
    input  logic    extended_mode,
    output result_t result
);

    // Width and gesture depend on the reporting mode of the pad.
    always_comb
    begin
        result.button_bits = packet.byte0[1:0];
        result.pressure    = packet.byte2;
        if (extended_mode)
        begin
            result.finger_width = {packet.byte0[5], packet.byte0[4],
                                   packet.byte0[2], packet.byte3[2]};
            result.gesture_flag = 1'b0;
        end
        else
        begin
            result.finger_width = packet.byte0[5] ? WIDTH_FINGER : WIDTH_NONE;
            result.gesture_flag = packet.byte0[2];
        end
        result.x_position = {packet.byte3[4], packet.byte1[3:0], packet.byte4};
        result.y_position = {packet.byte3[5], packet.byte1[7:4], packet.byte5};
    end

endmodule

/* src/touchpad_packet_deframer.sv */
// ----------------------------------------------------------------------------
// touchpad_packet_deframer
// Assembles six-byte absolute touchpad packets and reports decoded fields.
// ----------------------------------------------------------------------------
// The block accepts one touchpad byte per cycle unless stalled and produces
// one result per valid six-byte packet. Each byte goes into an input register,
// is checked and stored in a single pass, and the decoded packet lands in the
// result register when the last byte is taken. A waiting result stalls only
// the final byte of the next packet; other bytes keep flowing. Bytes that fail
// the sync checks at positions zero and three are dropped without a result.
// The extended_mode register (reset 1) selects width and gesture decoding; the
// user must write it through the cfg channel while idle; nothing enforces it.
module touchpad_packet_deframer
    import tpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  button_bits,
    output logic [7:0]  pressure,
    output logic [3:0]  finger_width,
    output logic        gesture_flag,
    output logic [12:0] x_position,
    output logic [12:0] y_position
);

    logic       mode_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_comb;
    packet_t    packet;
    logic       packet_done;
    logic       out_free;
    logic       take;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Input stage: the held byte moves on unless it completes a packet
    // while the result register is still occupied.
    assign out_free = !out_valid_reg || out_ready;
    assign take     = in_valid_reg && (!packet_done || out_free);
    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= data_byte;
        end
    end

    tpd_framer u_framer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (in_valid_reg),
        .byte_data   (in_byte_reg),
        .take        (take),
        .packet_done (packet_done),
        .packet      (packet)
    );

    tpd_decode u_decode
    (
        .packet        (packet),
        .extended_mode (mode_reg),
        .result        (result_comb)
    );

    // Result register.
    always_comb
    begin
        if (take && packet_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && packet_done)
        begin
            result_reg <= result_comb;
        end
    end

    assign out_valid    = out_valid_reg;
    assign button_bits  = result_reg.button_bits;
    assign pressure     = result_reg.pressure;
    assign finger_width = result_reg.finger_width;
    assign gesture_flag = result_reg.gesture_flag;
    assign x_position   = result_reg.x_position;
    assign y_position   = result_reg.y_position;

endmodule

/* tb/sv/tb_touchpad_packet_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_touchpad_packet_deframer
// Self-checking testbench for the touchpad packet deframer.
// ----------------------------------------------------------------------------
// Touchpad bytes are streamed into the block and every accepted byte runs
// through a local decoder that tracks the packet position, the stored bytes
// and the width mode. Completed packets queue up an expected report, and each
// report the block hands over is compared field by field with the oldest one.
// A short directed sequence covers the field extremes and every sync failure.
// Three random phases follow, alternating the width mode and each with a
// different mix of sender and receiver stalls. One phase also holds the
// receiver off long enough for the block to back up and stall its input.
// ----------------------------------------------------------------------------
module tb_touchpad_packet_deframer;
    import tpd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 12;
    // Worst legal gap is the long receiver hold-off plus a few stalls.
    localparam int WATCHDOG_LIMIT = 2000;
    // Margin waited after the last expected report has come back.
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLD_CYCLES    = 120;
    localparam int PHASE_BYTES    = 180;

    // Decodes accepted bytes and keeps the reports still owed by the block.
    class deframe_scoreboard;
        bit         extended_mode;
        logic [2:0] next_pos;
        logic [7:0] stored [PACKET_BYTES-1];
        result_t    expected_reports [$];
        int         mismatches;
        int         bytes_used;
        int         bytes_dropped;
        int         reports_checked;

        function new();
            extended_mode   = 1'b1;
            next_pos        = POS_FIRST;
            mismatches      = 0;
            bytes_used      = 0;
            bytes_dropped   = 0;
            reports_checked = 0;
            foreach (stored[i])
                stored[i] = 8'h00;
        endfunction

        function void set_mode(bit mode);
            extended_mode = mode;
        endfunction

        // Applies one accepted byte to the decoder state.
        function void take_byte(logic [7:0] b);
            result_t    r;
            logic [7:0] b0;
            logic [7:0] b1;
            logic [7:0] b3;

            // A set bit 3 in either sync byte restarts the packet.
            if ((next_pos == POS_FIRST || next_pos == POS_SYNC2) && b[SYNC_CLEAR_BIT])
            begin
                next_pos = POS_FIRST;
                bytes_dropped++;
                return;
            end
            // A first byte without its sync pattern is skipped in place.
            if (next_pos == POS_FIRST && b[7:6] != SYNC_TOP_FIRST)
            begin
                bytes_dropped++;
                return;
            end
            if (next_pos == POS_SYNC2 && b[7:6] != SYNC_TOP_SECOND)
            begin
                next_pos = POS_FIRST;
                bytes_dropped++;
                return;
            end

            bytes_used++;
            if (next_pos < POS_LAST)
            begin
                stored[next_pos] = b;
                next_pos = next_pos + 3'd1;
                return;
            end

            // The last byte completes the packet.
            next_pos      = POS_FIRST;
            b0            = stored[0];
            b1            = stored[1];
            b3            = stored[3];
            r.button_bits = b0[1:0];
            r.pressure    = stored[2];
            if (extended_mode)
            begin
                r.finger_width = {b0[5], b0[4], b0[2], b3[2]};
                r.gesture_flag = 1'b0;
            end
            else
            begin
                r.finger_width = b0[5] ? WIDTH_FINGER : WIDTH_NONE;
                r.gesture_flag = b0[2];
            end
            r.x_position = {b3[4], b1[3:0], stored[4]};
            r.y_position = {b3[5], b1[7:4], b};
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Checks one report handed over by the block.
        function void check_report(result_t got);
            result_t want;

            if (expected_reports.size() == 0)
            begin
                mismatches++;
                $display("%0t: report with none expected, actual x %0d y %0d pressure %0d",
                         $time, got.x_position, got.y_position, got.pressure);
                return;
            end
            want = expected_reports.pop_front();
            reports_checked++;
            compare_field("button_bits", want.button_bits, got.button_bits);
            compare_field("pressure", want.pressure, got.pressure);
            compare_field("finger_width", want.finger_width, got.finger_width);
            compare_field("gesture_flag", want.gesture_flag, got.gesture_flag);
            compare_field("x_position", want.x_position, got.x_position);
            compare_field("y_position", want.y_position, got.y_position);
        endfunction

        function int outstanding();
            return expected_reports.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  button_bits;
    logic [7:0]  pressure;
    logic [3:0]  finger_width;
    logic        gesture_flag;
    logic [12:0] x_position;
    logic [12:0] y_position;

    int send_gap_pct  = 0;
    int recv_gap_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    deframe_scoreboard sb = new();

    touchpad_packet_deframer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .button_bits  (button_bits),
        .pressure     (pressure),
        .finger_width (finger_width),
        .gesture_flag (gesture_flag),
        .x_position   (x_position),
        .y_position   (y_position)
    );

    // Free-running clock, 10 ns period.
    always
    begin
        clk = 1'b0;
        #(CLK_HALF);
        clk = 1'b1;
        #(CLK_HALF);
    end

    // Observe every completed transaction on the three channels.
    always @(posedge clk)
    begin : observe
        result_t seen;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_mode(cfg_data);
            if (out_valid && out_ready)
            begin
                seen.button_bits  = button_bits;
                seen.pressure     = pressure;
                seen.finger_width = finger_width;
                seen.gesture_flag = gesture_flag;
                seen.x_position   = x_position;
                seen.y_position   = y_position;
                sb.check_report(seen);
            end
            if (in_valid && in_ready)
                sb.take_byte(data_byte);
        end
    end

    // End the run if no transaction completes for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d reports outstanding",
                         $time, sb.outstanding());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end

    // Offers one byte and waits for its transaction.
    task automatic send_byte(input logic [7:0] value);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_bytes(input logic [7:0] seq [PACKET_BYTES], input int count);
        for (int i = 0; i < count; i++)
            send_byte(seq[i]);
    endtask

    // Writes the width mode; only called while the block is idle.
    task automatic write_mode(input bit mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stops offering bytes and waits until every report has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Sends one well-formed packet, a broken one, or a stray byte.
    task automatic send_random_unit();
        logic [7:0] frame [PACKET_BYTES];
        logic [1:0] top;
        int         kind;

        foreach (frame[i])
            frame[i] = 8'($urandom);
        frame[0][7:6]            = SYNC_TOP_FIRST;
        frame[0][SYNC_CLEAR_BIT] = 1'b0;
        frame[3][7:6]            = SYNC_TOP_SECOND;
        frame[3][SYNC_CLEAR_BIT] = 1'b0;
        kind = $urandom_range(0, 99);

        if (kind < 74)
            send_bytes(frame, PACKET_BYTES);
        else if (kind < 80)
        begin
            frame[0][SYNC_CLEAR_BIT] = 1'b1;
            send_bytes(frame, PACKET_BYTES);
        end
        else if (kind < 84)
        begin
            do
                top = 2'($urandom);
            while (top == SYNC_TOP_FIRST);
            frame[0][7:6] = top;
            send_bytes(frame, PACKET_BYTES);
        end
        else if (kind < 88)
        begin
            frame[3][SYNC_CLEAR_BIT] = 1'b1;
            send_bytes(frame, PACKET_BYTES);
        end
        else if (kind < 92)
        begin
            do
                top = 2'($urandom);
            while (top == SYNC_TOP_SECOND);
            frame[3][7:6] = top;
            send_bytes(frame, PACKET_BYTES);
        end
        else if (kind < 96)
            // Packet cut short; the next one lands mid-packet.
            send_bytes(frame, $urandom_range(1, PACKET_BYTES - 1));
        else
            send_byte(8'($urandom));
    endtask

    // One random phase in a given width mode with given stall rates.
    task automatic run_phase(input bit mode, input int send_pct, input int recv_pct,
                             input bit with_hold);
        int goal;

        write_mode(mode);
        send_gap_pct = send_pct;
        recv_gap_pct = recv_pct;
        goal = sb.bytes_used + PHASE_BYTES;
        if (with_hold)
            hold_requests++;
        while (sb.bytes_used < goal)
            send_random_unit();
        settle();
    endtask

    // Main sequence.
    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        in_valid  = 1'b0;
        data_byte = 8'h00;
        out_ready = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Extended mode: all-ones fields, then every sync failure.
        write_mode(1'b1);
        send_bytes('{8'hB7, 8'hFF, 8'hFF, 8'hF7, 8'hFF, 8'hFF}, PACKET_BYTES);
        send_byte(8'h88);
        send_byte(8'h40);
        send_bytes('{8'h80, 8'h00, 8'h00, 8'hC8, 8'h00, 8'h00}, 4);
        settle();

        // Non-extended mode: bad second sync, finger with gesture, all zeros.
        write_mode(1'b0);
        send_bytes('{8'h80, 8'h12, 8'h34, 8'h70, 8'h00, 8'h00}, 4);
        send_bytes('{8'hB7, 8'h5A, 8'hA5, 8'hF7, 8'h3C, 8'hC3}, PACKET_BYTES);
        send_bytes('{8'h80, 8'h00, 8'h00, 8'hC0, 8'h00, 8'h00}, PACKET_BYTES);
        settle();

        // Random phases with changing stall mixes.
        run_phase(1'b1, 16, 48, 1'b0);
        run_phase(1'b0, 48, 16, 1'b0);
        run_phase(1'b1, 0, 0, 1'b1);

        $display("Run covered %0d packet bytes, %0d sync-dropped bytes and %0d reports,",
                 sb.bytes_used, sb.bytes_dropped, sb.reports_checked);
        $display("in both width modes, under stalls on either side and one long hold-off.");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* touchpad_packet_deframer.f */
src/tpd_pkg.sv
src/tpd_framer.sv
src/tpd_decode.sv
src/touchpad_packet_deframer.sv
tb/sv/tb_touchpad_packet_deframer.sv
